[rtl/core/u8dv_pkg.sv]
// ----------------------------------------------------------------------------
// u8dv_pkg
// shared types, constants and helpers for the utf-8 stream decoder/validator
// ----------------------------------------------------------------------------
package u8dv_pkg;

  localparam int BYTE_W  = 8;
  localparam int CP_W    = 21;
  localparam int LEN_W   = 3;
  localparam int SLOTS   = 4;
  localparam int SLOT_CNT_W = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CP_W-1:0] CP_MIN_2 = 21'h00080;
  localparam logic [CP_W-1:0] CP_MIN_3 = 21'h00800;
  localparam logic [CP_W-1:0] CP_MIN_4 = 21'h10000;
  localparam logic [CP_W-1:0] CP_SUR_LO = 21'h0D800;
  localparam logic [CP_W-1:0] CP_SUR_HI = 21'h0DFFF;
  localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;

  localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_buffer;
  } in_beat_t;

  typedef struct packed {
    logic [CP_W-1:0]  unit_value;
    logic [LEN_W-1:0] unit_length;
    logic             unit_valid;
    logic             last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic [CP_W-1:0]  value;
    logic [LEN_W-1:0] length;
    logic             valid;
  } result_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [SLOT_CNT_W-1:0] count;
    result_t [SLOTS-1:0]   slot;
  } job_t;

  // handshake between the front and the queue
  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

  function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] len;
    len = LEN_1;
    if (b[7:5] == 3'b110) len = LEN_2;
    else if (b[7:4] == 4'b1110) len = LEN_3;
    else if (b[7:3] == 5'b11110) len = LEN_4;
    return len;
  endfunction

  function automatic logic cp_ok(input logic [CP_W-1:0] cp, input logic [LEN_W-1:0] len);
    logic ok;
    ok = 1'b1;
    if (len == LEN_2 && cp < CP_MIN_2) ok = 1'b0;
    if (len == LEN_3 && cp < CP_MIN_3) ok = 1'b0;
    if (len == LEN_4 && cp < CP_MIN_4) ok = 1'b0;
    if (cp >= CP_SUR_LO && cp <= CP_SUR_HI) ok = 1'b0;
    if (cp > CP_MAX) ok = 1'b0;
    return ok;
  endfunction

endpackage

[rtl/core/u8dv_front.sv]
// ----------------------------------------------------------------------------
// u8dv_front
// takes one byte per beat, tracks the partial sequence and builds the job
// ----------------------------------------------------------------------------
module u8dv_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  u8dv_pkg::in_beat_t in_beat,
  input  logic              full,
  output u8dv_pkg::push_t   push
);
  import u8dv_pkg::*;

  logic [1:0]        pcount, pcount_next;
  logic [LEN_W-1:0]  exp_len, exp_len_next;
  logic [CP_W-1:0]   partial, partial_next;
  logic [BYTE_W-1:0] pend [3];

  logic              accept;
  logic [BYTE_W-1:0] b;
  logic              eob;
  logic              cont;
  logic [CP_W-1:0]   part_ext;
  logic              complete;
  logic [LEN_W-1:0]  len;
  logic [1:0]        flush_n;
  logic              tail_present;
  result_t           tail;
  logic              pend_we;
  logic [1:0]        pend_idx;
  job_t              job;

  assign b        = in_beat.data_byte;
  assign eob      = in_beat.end_of_buffer;
  assign cont     = (b[7:6] == 2'b10);
  assign part_ext = {partial[CP_W-7:0], b[5:0]};
  assign complete = ({1'b0, pcount} + 3'd1) >= exp_len;
  assign len      = lead_length(b);
  assign accept   = in_valid && !full;
  assign in_stall = full;

  always_comb begin
    flush_n      = 2'd0;
    tail_present = 1'b0;
    tail         = '0;
    pend_we      = 1'b0;
    pend_idx     = 2'd0;
    pcount_next  = pcount;
    exp_len_next = exp_len;
    partial_next = partial;
    if (pcount != 2'd0 && cont) begin
      pcount_next  = 2'd0;
      exp_len_next = '0;
      partial_next = '0;
      tail_present = 1'b1;
      if (complete && cp_ok(part_ext, exp_len)) begin
        tail = '{value: part_ext, length: exp_len, valid: 1'b1};
      end else if (complete || eob) begin
        flush_n = pcount;
        tail    = '{value: {{(CP_W-BYTE_W){1'b0}}, b}, length: LEN_1, valid: 1'b0};
      end else begin
        tail_present = 1'b0;
        pend_we      = 1'b1;
        pend_idx     = pcount;
        pcount_next  = pcount + 2'd1;
        exp_len_next = exp_len;
        partial_next = part_ext;
      end
    end else begin
      if (pcount != 2'd0) begin
        flush_n      = pcount;
        pcount_next  = 2'd0;
        exp_len_next = '0;
        partial_next = '0;
      end
      if (len == LEN_1) begin
        tail_present = 1'b1;
        tail = '{value: {{(CP_W-BYTE_W){1'b0}}, b}, length: LEN_1, valid: !b[7]};
      end else if (eob) begin
        tail_present = 1'b1;
        tail = '{value: {{(CP_W-BYTE_W){1'b0}}, b}, length: LEN_1, valid: 1'b0};
      end else begin
        pend_we      = 1'b1;
        pend_idx     = 2'd0;
        pcount_next  = 2'd1;
        exp_len_next = len;
        case (len)
          LEN_2:   partial_next = {{(CP_W-5){1'b0}}, b[4:0]};
          LEN_3:   partial_next = {{(CP_W-4){1'b0}}, b[3:0]};
          default: partial_next = {{(CP_W-3){1'b0}}, b[2:0]};
        endcase
      end
    end
  end

  always_comb begin
    job.count = {1'b0, flush_n} + {2'b00, tail_present};
    for (int j = 0; j < SLOTS; j++) begin
      if (j < 3 && 2'(j) < flush_n) begin
        job.slot[j] = '{value: {{(CP_W-BYTE_W){1'b0}}, pend[j[1:0]]},
                        length: LEN_1, valid: 1'b0};
      end else begin
        job.slot[j] = tail;
      end
    end
  end

  assign push.push = accept && (job.count != '0);
  assign push.job  = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount  <= 2'd0;
      exp_len <= '0;
      partial <= '0;
    end else if (accept) begin
      pcount  <= pcount_next;
      exp_len <= exp_len_next;
      partial <= partial_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pend_we && pend_idx != 2'd3) begin
      pend[pend_idx] <= b;
    end
  end

  a_pend_len: assert property (@(posedge clk) disable iff (rst)
    pcount != 2'd0 |-> ({1'b0, pcount} < exp_len) && (exp_len >= LEN_2) && (exp_len <= LEN_4))
    else $error("pending count out of range for expected length");

  a_job_count: assert property (@(posedge clk) disable iff (rst)
    push.push |-> push.job.count <= 3'(SLOTS))
    else $error("job holds more results than slots");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    accept && flush_n != 2'd0 && !pend_we |=> pcount == 2'd0)
    else $error("flushed sequence left pending bytes");

endmodule

[rtl/core/u8dv_queue.sv]
// ----------------------------------------------------------------------------
// u8dv_queue
// small job queue between the front and the back
// ----------------------------------------------------------------------------
module u8dv_queue #(
  parameter int DEPTH = u8dv_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  u8dv_pkg::push_t push,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output u8dv_pkg::job_t  head
);
  import u8dv_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push.job;
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push.push |-> !full)
    else $error("push into full queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow push");

endmodule

[rtl/core/u8dv_back.sv]
// ----------------------------------------------------------------------------
// u8dv_back
// walks each job one result per beat into the output register
// ----------------------------------------------------------------------------
module u8dv_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  u8dv_pkg::job_t      head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output u8dv_pkg::out_beat_t out_beat
);
  import u8dv_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       last;
  result_t    cur;

  assign load = !empty && (!out_valid || !out_stall);
  assign last = ({1'b0, idx} == (head.count - 3'd1));
  assign cur  = head.slot[idx];
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? 2'd0 : idx + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_beat.unit_value  <= cur.value;
      out_beat.unit_length <= cur.length;
      out_beat.unit_valid  <= cur.valid;
      out_beat.last_of_run <= last;
    end
  end

  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    empty |-> idx == 2'd0)
    else $error("result index left mid-job with empty queue");

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    !empty |-> {1'b0, idx} < head.count)
    else $error("result index beyond job count");

  a_last_pops: assert property (@(posedge clk) disable iff (rst)
    load && last |=> idx == 2'd0)
    else $error("index not reset after last result");

endmodule

[rtl/core/utf8_stream_decode_validate_top.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decode_validate_top
// streaming utf-8 decoder and validator, one byte per input beat
//
// input channel: in_valid/in_stall with in_beat {data_byte, end_of_buffer}
// output channel: out_valid/out_stall with out_beat {unit_value, unit_length,
// unit_valid, last_of_run}; a beat is taken when valid is high, stall low
// each byte gives zero to four results: a decoded code point, or the bytes
// of a rejected sequence one by one as invalid; last_of_run marks the final
// result of a byte
// a byte's results are written into the job queue, then loaded into the output register
// throughput: one byte per cycle in while in_stall is low, one result per
// cycle out while out_stall is low; a byte that flushes a broken sequence
// gives up to four results, absorbed by a QUEUE_DEPTH-entry job queue
// between front and back; in_stall rises only when that queue is full
// reset clears the partial sequence, the queue and the output register
// when the receiver stalls the output beat holds, the queue fills, then
// in_stall is raised
// ----------------------------------------------------------------------------
module utf8_stream_decode_validate_top #(
  parameter int QUEUE_DEPTH = u8dv_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  u8dv_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output u8dv_pkg::out_beat_t out_beat
);
  import u8dv_pkg::*;

  push_t push;
  job_t  head;
  logic  full, empty, pop;

  u8dv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .full     (full),
    .push     (push)
  );

  u8dv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .pop   (pop),
    .empty (empty),
    .head  (head)
  );

  u8dv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming utf-8 decoder and validator
//
// drives bytes through the valid/stall input channel and predicts every
// result with a behavioral decoder kept in a scoreboard class; each output
// beat is compared field by field with the oldest predicted unit. a short
// directed opening covers the extremes and the rejection paths, then random
// well-formed sequences mixed with broken ones and noise run under three
// backpressure profiles, draining between profiles
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import u8dv_pkg::*;

  class utf8_scoreboard;
    out_beat_t   expected_units[$];
    out_beat_t   step_units[$];
    int unsigned mismatches;
    logic [7:0]  held_bytes[3];
    logic [1:0]  held_count;
    logic [2:0]  want_len;
    logic [20:0] code_acc;

    function new();
      mismatches = 0;
      held_count = '0;
      want_len   = '0;
      code_acc   = '0;
      foreach (held_bytes[i]) held_bytes[i] = '0;
    endfunction

    function void emit(logic [20:0] value, logic [2:0] len, logic ok);
      out_beat_t u;
      u.unit_value  = value;
      u.unit_length = len;
      u.unit_valid  = ok;
      u.last_of_run = 1'b0;
      step_units.push_back(u);
    endfunction

    function void drop_held();
      for (int j = 0; j < held_count; j++) emit({13'd0, held_bytes[j]}, LEN_1, 1'b0);
      held_count = '0;
      want_len   = '0;
      code_acc   = '0;
    endfunction

    function bit legal_point(logic [20:0] cp, logic [2:0] len);
      logic [20:0] floor_cp;
      case (len)
        LEN_2:   floor_cp = CP_MIN_2;
        LEN_3:   floor_cp = CP_MIN_3;
        LEN_4:   floor_cp = CP_MIN_4;
        default: floor_cp = '0;
      endcase
      return (cp >= floor_cp) && (cp <= CP_MAX) && !(cp >= CP_SUR_LO && cp <= CP_SUR_HI);
    endfunction

    function void note_byte(in_beat_t beat);
      logic [7:0] b;
      logic       eob;
      logic [2:0] claim;
      bit         taken;
      out_beat_t  u;
      b     = beat.data_byte;
      eob   = beat.end_of_buffer;
      taken = 1'b0;
      step_units.delete();
      if (held_count != 0) begin
        if (b[7:6] == 2'b10) begin
          taken    = 1'b1;
          code_acc = {code_acc[14:0], b[5:0]};
          if (held_count + 1 >= want_len) begin
            if (legal_point(code_acc, want_len)) begin
              emit(code_acc, want_len, 1'b1);
              held_count = '0;
              want_len   = '0;
              code_acc   = '0;
            end else begin
              drop_held();
              emit({13'd0, b}, LEN_1, 1'b0);
            end
          end else if (eob) begin
            drop_held();
            emit({13'd0, b}, LEN_1, 1'b0);
          end else begin
            held_bytes[held_count] = b;
            held_count++;
          end
        end else begin
          drop_held();
        end
      end
      if (!taken) begin
        casez (b)
          8'b110?????: claim = LEN_2;
          8'b1110????: claim = LEN_3;
          8'b11110???: claim = LEN_4;
          default:     claim = LEN_1;
        endcase
        if (claim == LEN_1) begin
          emit({13'd0, b}, LEN_1, !b[7]);
        end else if (eob) begin
          emit({13'd0, b}, LEN_1, 1'b0);
        end else begin
          held_bytes[0] = b;
          held_count    = 2'd1;
          want_len      = claim;
          case (claim)
            LEN_2:   code_acc = {16'd0, b[4:0]};
            LEN_3:   code_acc = {17'd0, b[3:0]};
            default: code_acc = {18'd0, b[2:0]};
          endcase
        end
      end
      foreach (step_units[i]) begin
        u = step_units[i];
        u.last_of_run = (i == step_units.size() - 1);
        expected_units.push_back(u);
      end
    endfunction

    function void check_unit(out_beat_t got);
      out_beat_t want;
      if (expected_units.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat: expected none actual %h", $time, got);
        return;
      end
      want = expected_units.pop_front();
      if (got.unit_value !== want.unit_value) begin
        mismatches++;
        $display("%0t: unit_value expected %h actual %h", $time, want.unit_value,
                 got.unit_value);
      end
      if (got.unit_length !== want.unit_length) begin
        mismatches++;
        $display("%0t: unit_length expected %0d actual %0d", $time, want.unit_length,
                 got.unit_length);
      end
      if (got.unit_valid !== want.unit_valid) begin
        mismatches++;
        $display("%0t: unit_valid expected %b actual %b", $time, want.unit_valid,
                 got.unit_valid);
      end
      if (got.last_of_run !== want.last_of_run) begin
        mismatches++;
        $display("%0t: last_of_run expected %b actual %b", $time, want.last_of_run,
                 got.last_of_run);
      end
    endfunction

    function int outstanding();
      return expected_units.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  int unsigned send_gap_pct   = 15;
  int unsigned sink_stall_pct = 67;
  int unsigned bytes_sent     = 0;

  utf8_scoreboard sb = new();

  utf8_stream_decode_validate_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_unit(out_beat);
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic eob);
    in_beat_t beat;
    beat.data_byte     = b;
    beat.end_of_buffer = eob;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(beat);
    bytes_sent++;
  endtask

  task automatic send_random_unit();
    logic [7:0]  seq[4];
    logic [7:0]  odd_leads[9];
    logic [20:0] cp;
    int          kind;
    int          n;
    int          cut;
    odd_leads = '{8'hC0, 8'hC1, 8'hE0, 8'hED, 8'hF0, 8'hF4, 8'hF5, 8'hF6, 8'hF7};
    kind = $urandom_range(9);
    if (kind <= 6) begin
      n = $urandom_range(1, 4);
      case (n)
        1: cp = 21'($urandom_range(0, 'h7F));
        2: cp = 21'($urandom_range('h80, 'h7FF));
        3: begin
          cp = 21'($urandom_range('h800, 'hFFFF));
          if (cp >= CP_SUR_LO && cp <= CP_SUR_HI) cp ^= 21'h08000;
        end
        default: cp = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
      case (n)
        1: seq[0] = cp[7:0];
        2: begin
          seq[0] = {3'b110, cp[10:6]};
          seq[1] = {2'b10, cp[5:0]};
        end
        3: begin
          seq[0] = {4'b1110, cp[15:12]};
          seq[1] = {2'b10, cp[11:6]};
          seq[2] = {2'b10, cp[5:0]};
        end
        default: begin
          seq[0] = {5'b11110, cp[20:18]};
          seq[1] = {2'b10, cp[17:12]};
          seq[2] = {2'b10, cp[11:6]};
          seq[3] = {2'b10, cp[5:0]};
        end
      endcase
      // truncated sequence, the next unit interrupts it
      cut = (kind == 6 && n > 1) ? $urandom_range(1, n - 1) : n;
    end else if (kind == 7) begin
      seq[0] = odd_leads[$urandom_range(8)];
      n = (seq[0] < 8'hE0) ? 2 : (seq[0] < 8'hF0) ? 3 : 4;
      for (int i = 1; i < 4; i++) seq[i] = {2'b10, 6'($urandom_range(63))};
      cut = n;
    end else begin
      seq[0] = 8'($urandom_range(255));
      cut = 1;
    end
    for (int i = 0; i < cut; i++) send_byte(seq[i], $urandom_range(15) == 0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    // bit 8 marks end of buffer
    logic [8:0] opening[27];
    opening = '{9'h000, 9'h17F,
                9'h0C2, 9'h080,
                9'h0EF, 9'h0BF, 9'h0BF,
                9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
                9'h080,
                9'h0FF,
                9'h0C0, 9'h0AF,
                9'h0ED, 9'h0A0, 9'h080,
                9'h0F5, 9'h080, 9'h080, 9'h080,
                9'h0E2, 9'h041,
                9'h1C3,
                9'h0E2, 9'h182};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_gap_pct   = 15;
    sink_stall_pct = 67;
    foreach (opening[i]) send_byte(opening[i][7:0], opening[i][8]);
    while (bytes_sent < 130) send_random_unit();
    wait_drained();

    send_gap_pct   = 67;
    sink_stall_pct = 15;
    while (bytes_sent < 230) send_random_unit();
    wait_drained();

    send_gap_pct   = 0;
    sink_stall_pct = 0;
    while (bytes_sent < 330) send_random_unit();

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
